// File: rtl/core/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and defaults of the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned DUMP_W   = 7;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned PAGE_COUNT_DEF   = 4096;
  localparam int unsigned RECENT_DEPTH_DEF = 512;
  localparam int unsigned MAX_DUMP_DEF     = 64;
  localparam logic [PAGE_W-1:0] FIRST_FREE_RST = 12'd64;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_FREE  = 2'd1,
    OP_ALLOC = 2'd2,
    OP_DUMP  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_PAGE  = 3'd1,
    ST_BAD_PAGE = 3'd2,
    ST_TOO_MANY = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_STACK = 2'd1,
    SEL_LIST  = 2'd2
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      init_push;
    logic      list_clear;
    logic      push_page;
    logic      stack_rd;
    logic      list_rd;
    logic      list_rd_next;
    logic      idx_inc;
    logic      shift_wr;
    logic      count_dec;
    logic      alloc;
    logic      emit;
    emit_sel_e emit_sel;
    status_e   emit_status;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic bad;
    logic full;
    logic few;
    logic too_many;
    logic zero_n;
    logic init_more;
    logic init_ovf;
    logic srch_more;
    logic hit;
    logic shift_more;
    logic dump_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/pfa_in_if.sv
// ----------------------------------------------------------------------------
// pfa_in_if
// Request channel: operation, page and dump count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::OP_W-1:0]    op;
  logic [pfa_pkg::PAGE_W-1:0]  page;
  logic [pfa_pkg::DUMP_W-1:0]  dump_count;

  modport source (output valid, output op, output page, output dump_count, input ready);
  modport sink   (input valid, input op, input page, input dump_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pfa_out_if.sv
// ----------------------------------------------------------------------------
// pfa_out_if
// Result channel: page, status and last flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfa_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfa_pkg::PAGE_W-1:0]    page_res;
  logic [pfa_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, output page_res, output status, output last, input ready);
  modport sink   (input valid, input page_res, input status, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pfa_datapath.sv
// ----------------------------------------------------------------------------
// pfa_datapath
// Free stack and recent list memories, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_datapath #(
  parameter int unsigned PAGE_COUNT   = pfa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned RECENT_DEPTH = pfa_pkg::RECENT_DEPTH_DEF,
  parameter int unsigned MAX_DUMP     = pfa_pkg::MAX_DUMP_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfa_pkg::PAGE_W-1:0]     cfg_wdata_i,
  input  wire logic [pfa_pkg::OP_W-1:0]       in_op_i,
  input  wire logic [pfa_pkg::PAGE_W-1:0]     in_page_i,
  input  wire logic [pfa_pkg::DUMP_W-1:0]     in_dump_count_i,
  input  pfa_pkg::cmd_t                       cmd_i,
  output pfa_pkg::sts_t                       sts_o,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output logic [pfa_pkg::PAGE_W-1:0]          out_page_res_o,
  output logic [pfa_pkg::STATUS_W-1:0]        out_status_o,
  output logic                                out_last_o
);
  import pfa_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_COUNT);
  localparam int unsigned CW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned PW = (CW > PAGE_W) ? CW : PAGE_W;
  localparam int unsigned IW = $clog2(RECENT_DEPTH);
  localparam int unsigned RW = $clog2(RECENT_DEPTH + 1);

  logic [PAGE_W-1:0] stack_mem [PAGE_COUNT];
  logic [PAGE_W-1:0] list_mem  [RECENT_DEPTH];

  logic [PAGE_W-1:0] ffp_q;
  op_e               op_q;
  logic [PAGE_W-1:0] page_q;
  logic [DUMP_W-1:0] n_q;
  logic [CW-1:0]     cnt_q;
  logic [PW-1:0]     ptr_q;
  logic              ovf_q;
  logic [IW-1:0]     head_q;
  logic [RW-1:0]     rcnt_q;
  logic [RW-1:0]     idx_q;
  logic [PAGE_W-1:0] lrd_q;
  logic [PAGE_W-1:0] srd_q;
  logic              out_valid_q;
  logic [PAGE_W-1:0] out_page_q;
  status_e           out_status_q;
  logic              out_last_q;

  logic              full;
  logic              out_free;
  logic [IW-1:0]     head_dec;
  logic [IW-1:0]     lst_raddr;
  logic [IW-1:0]     lst_waddr;
  logic [PAGE_W-1:0] lst_wdata;
  logic              lst_we;
  logic              stk_we;
  logic [PAGE_W-1:0] stk_wdata;
  logic [PAGE_W-1:0] emit_page;

  // list position to memory slot, head is the newest entry
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [RW-1:0] x);
    logic [RW:0] s;
    s = (RW+1)'(head) + (RW+1)'(x);
    if (s >= (RW+1)'(RECENT_DEPTH)) begin
      s = s - (RW+1)'(RECENT_DEPTH);
    end
    return IW'(s);
  endfunction

  assign full      = (cnt_q == CW'(PAGE_COUNT));
  assign out_free  = !out_valid_q || out_ready_i;
  assign head_dec  = (head_q == '0) ? IW'(RECENT_DEPTH - 1) : head_q - IW'(1);
  assign lst_raddr = cmd_i.list_rd_next ? phys(head_q, idx_q + RW'(1)) : phys(head_q, idx_q);
  assign lst_we    = cmd_i.shift_wr || cmd_i.alloc;
  assign lst_waddr = cmd_i.alloc ? head_dec : phys(head_q, idx_q);
  assign lst_wdata = cmd_i.alloc ? srd_q : lrd_q;
  assign stk_we    = (cmd_i.init_push && !full) || cmd_i.push_page;
  assign stk_wdata = cmd_i.init_push ? PAGE_W'(ptr_q) : page_q;

  always_comb begin
    case (cmd_i.emit_sel)
      SEL_STACK: emit_page = srd_q;
      SEL_LIST:  emit_page = lrd_q;
      default:   emit_page = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[AW'(cnt_q)] <= stk_wdata;
    end
    if (cmd_i.stack_rd) begin
      srd_q <= stack_mem[AW'(cnt_q - CW'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lst_we) begin
      list_mem[lst_waddr] <= lst_wdata;
    end
    if (cmd_i.list_rd || cmd_i.list_rd_next) begin
      lrd_q <= list_mem[lst_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ffp_q        <= FIRST_FREE_RST;
      op_q         <= OP_INIT;
      page_q       <= '0;
      n_q          <= '0;
      cnt_q        <= '0;
      ptr_q        <= '0;
      ovf_q        <= 1'b0;
      head_q       <= '0;
      rcnt_q       <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_page_q   <= '0;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ffp_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        op_q   <= op_e'(in_op_i);
        page_q <= in_page_i;
        n_q    <= in_dump_count_i;
        idx_q  <= '0;
        ptr_q  <= PW'(ffp_q);
        ovf_q  <= 1'b0;
      end
      if (cmd_i.init_push) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
        ptr_q <= ptr_q + PW'(1);
      end
      if (cmd_i.list_clear) begin
        rcnt_q <= '0;
      end
      if (cmd_i.push_page) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.idx_inc || cmd_i.shift_wr) begin
        idx_q <= idx_q + RW'(1);
      end
      if (cmd_i.count_dec) begin
        rcnt_q <= rcnt_q - RW'(1);
      end
      if (cmd_i.alloc) begin
        cnt_q  <= cnt_q - CW'(2);
        head_q <= head_dec;
        // a full list loses its oldest entry to the new slot
        if (rcnt_q != RW'(RECENT_DEPTH)) begin
          rcnt_q <= rcnt_q + RW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q  <= 1'b1;
        out_page_q   <= emit_page;
        out_status_q <= cmd_i.emit_status;
        out_last_q   <= cmd_i.emit_last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.bad        = (page_q < ffp_q) || (32'(page_q) >= PAGE_COUNT);
    sts_o.full       = full;
    sts_o.few        = (cnt_q < CW'(2));
    sts_o.too_many   = (32'(n_q) > 32'(rcnt_q)) || (32'(n_q) > MAX_DUMP);
    sts_o.zero_n     = (n_q == '0);
    sts_o.init_more  = (32'(ptr_q) < PAGE_COUNT);
    sts_o.init_ovf   = ovf_q;
    sts_o.srch_more  = (idx_q < rcnt_q);
    sts_o.hit        = (lrd_q == page_q);
    sts_o.shift_more = ((32'(idx_q) + 32'd1) < 32'(rcnt_q));
    sts_o.dump_last  = ((32'(idx_q) + 32'd1) == 32'(n_q));
    sts_o.out_free   = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign out_page_res_o = out_page_q;
  assign out_status_o   = out_status_q;
  assign out_last_o     = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer for init, free, allocate and dump operations.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  pfa_pkg::sts_t sts_i,
  output pfa_pkg::cmd_t cmd_o
);
  import pfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INIT, S_SRCH, S_SRCH_CHK, S_SHIFT, S_SHIFT_WR,
    S_ALLOC, S_DUMP_RD, S_DUMP_OUT, S_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_sel    = SEL_ZERO;
    cmd_o.emit_status = ST_OK;
    state_d           = state_q;
    code_d            = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_INIT: state_d = S_INIT;
          OP_FREE: begin
            if (sts_i.bad) begin
              code_d  = ST_BAD_PAGE;
              state_d = S_RESP;
            end else if (sts_i.full) begin
              code_d  = ST_FULL;
              state_d = S_RESP;
            end else begin
              cmd_o.push_page = 1'b1;
              state_d         = S_SRCH;
            end
          end
          OP_ALLOC: begin
            if (sts_i.few) begin
              code_d  = ST_NO_PAGE;
              state_d = S_RESP;
            end else begin
              cmd_o.stack_rd = 1'b1;
              state_d        = S_ALLOC;
            end
          end
          OP_DUMP: begin
            if (sts_i.too_many) begin
              code_d  = ST_TOO_MANY;
              state_d = S_RESP;
            end else if (sts_i.zero_n) begin
              code_d  = ST_OK;
              state_d = S_RESP;
            end else begin
              state_d = S_DUMP_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_INIT: begin
        if (sts_i.init_more) begin
          cmd_o.init_push = 1'b1;
        end else begin
          cmd_o.list_clear = 1'b1;
          code_d           = sts_i.init_ovf ? ST_FULL : ST_OK;
          state_d          = S_RESP;
        end
      end
      S_SRCH: begin
        if (sts_i.srch_more) begin
          cmd_o.list_rd = 1'b1;
          state_d       = S_SRCH_CHK;
        end else begin
          code_d  = ST_OK;
          state_d = S_RESP;
        end
      end
      S_SRCH_CHK: begin
        if (sts_i.hit) begin
          state_d = S_SHIFT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SRCH;
        end
      end
      // close the gap by moving older entries one place toward the front
      S_SHIFT: begin
        if (sts_i.shift_more) begin
          cmd_o.list_rd_next = 1'b1;
          state_d            = S_SHIFT_WR;
        end else begin
          cmd_o.count_dec = 1'b1;
          code_d          = ST_OK;
          state_d         = S_RESP;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT;
      end
      S_ALLOC: begin
        if (sts_i.out_free) begin
          cmd_o.alloc       = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_sel    = SEL_STACK;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd_o.list_rd = 1'b1;
        state_d       = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_sel    = SEL_LIST;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = sts_i.dump_last;
          cmd_o.idx_inc     = 1'b1;
          state_d           = sts_i.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_sel    = SEL_ZERO;
          cmd_o.emit_status = code_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/page_frame_allocator_with_recent_list.sv
// Page frame allocator: a LIFO stack of free page numbers plus a newest-first
// list of allocated pages, one request at a time. The sequencer walks the
// stack and list memories step by step: init pushes one page a cycle from
// the first free page up to PAGE_COUNT; free pushes the page, then searches
// the list and, on a hit, shifts the older entries toward the front, with a
// read state and a check or write state for each compare and each shift step;
// allocate reads the stack top and then emits it; dump reads and emits N
// entries, one read state and one output state per entry. Results leave through a
// registered output stage, so a result may wait there while the next request
// is already taken.
// ----------------------------------------------------------------------------
// page_frame_allocator_with_recent_list
// Top level: sequencer, datapath and channel hookup.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator_with_recent_list #(
  parameter int unsigned PAGE_COUNT   = pfa_pkg::PAGE_COUNT_DEF,
  parameter int unsigned RECENT_DEPTH = pfa_pkg::RECENT_DEPTH_DEF,
  parameter int unsigned MAX_DUMP     = pfa_pkg::MAX_DUMP_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [pfa_pkg::PAGE_W-1:0] cfg_wdata_i,
  pfa_in_if.sink                          in_i,
  pfa_out_if.source                       out_o
);
  import pfa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfa_datapath #(
    .PAGE_COUNT   (PAGE_COUNT),
    .RECENT_DEPTH (RECENT_DEPTH),
    .MAX_DUMP     (MAX_DUMP)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_op_i         (in_i.op),
    .in_page_i       (in_i.page),
    .in_dump_count_i (in_i.dump_count),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_page_res_o  (out_o.page_res),
    .out_status_o    (out_o.status),
    .out_last_o      (out_o.last)
  );

endmodule

`default_nettype wire

// File: rtl/core/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_port_checks
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_port_checks (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [pfa_pkg::PAGE_W-1:0]     out_page_res_i,
  input wire logic [pfa_pkg::STATUS_W-1:0]   out_status_i,
  input wire logic                           out_last_i
);
  import pfa_pkg::*;

  // a pending result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i <= ST_FULL))
    else $error("status code out of range");

  // error results are single, final and carry no page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_last_i && (out_page_res_i == '0))
    else $error("error result malformed");

  // requests are taken one at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

endmodule

bind page_frame_allocator_with_recent_list pfa_port_checks u_pfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_page_res_i (out_o.page_res),
  .out_status_i   (out_o.status),
  .out_last_i     (out_o.last)
);

`default_nettype wire
